>>> design/li_chao_segment_max_macros.svh
// Assertion helpers for the Li Chao max block.
`ifndef LI_CHAO_SEGMENT_MAX_MACROS_SVH
`define LI_CHAO_SEGMENT_MAX_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LCS_ASSERT_IMP(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lcs: assertion failed");
// next-cycle implication
`define LCS_ASSERT_NXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lcs: assertion failed");
`else
`define LCS_ASSERT_IMP(lbl, ck, rst_n, ante, cons)
`define LCS_ASSERT_NXT(lbl, ck, rst_n, ante, cons)
`endif
`endif

>>> design/lcs_pkg.sv
package lcs_pkg;

	localparam int unsigned LEAVES_DEF = 1024;
	localparam int unsigned POS_W      = 10;
	localparam int unsigned SLOPE_W    = 32;
	localparam int unsigned ICPT_W     = 48;
	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned LINE_W     = SLOPE_W + ICPT_W;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// cleared node holds the line y = -1
	localparam logic [SLOPE_W-1:0] CLR_SLOPE = '0;
	localparam logic [ICPT_W-1:0]  CLR_ICPT  = '1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COVER,
		ST_RD,
		ST_MUL,
		ST_CMP
	} lcs_state_t;

endpackage

>>> design/li_chao_segment_max.sv
// Channel   Handshake              Payload
// -------   ---------------------  ------------------------------------------------
// in        start && !busy         kind, line_slope, line_intercept, x_first, x_last,
//                                  query_x
// out       done (one-cycle beat)  max_value
//
// Every tree node lives in one line RAM (2*T entries, T = LEAVES rounded up to a power
// of two); each node visit is a read, a multiply and a compare/write.
// Query: visits the leaf and each ancestor up to the root; done follows in the cycle
// after the root's compare. Out-of-range query: answered from idle with no node visit.
// Insert: up to 2*log2(T) covering nodes, each pushed down one level per node visit to a
// leaf, with covering steps between. An empty or out-of-range insert leaves busy low.
// After reset a clearing pass writes all 2*T entries with busy high.
// The receiver cannot stall: done is a single-cycle strobe.
`include "li_chao_segment_max_macros.svh"

module li_chao_segment_max #(
	parameter int unsigned LEAVES = lcs_pkg::LEAVES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               kind,
	input  logic signed [lcs_pkg::SLOPE_W-1:0] line_slope,
	input  logic signed [lcs_pkg::ICPT_W-1:0]  line_intercept,
	input  logic        [lcs_pkg::POS_W-1:0]   x_first,
	input  logic        [lcs_pkg::POS_W-1:0]   x_last,
	input  logic        [lcs_pkg::POS_W-1:0]   query_x,
	output logic                               done,
	output logic signed [lcs_pkg::VALUE_W-1:0] max_value
);

	localparam int unsigned SW    = lcs_pkg::SLOPE_W;
	localparam int unsigned BW    = lcs_pkg::ICPT_W;
	localparam int unsigned PW    = $clog2(LEAVES);
	localparam int unsigned TREE  = 1 << PW;
	localparam int unsigned NW    = PW + 1;
	localparam int unsigned DEPTH = 2 * TREE;
	localparam int unsigned LW    = $clog2(PW + 1);
	localparam int unsigned CW    = ((lcs_pkg::POS_W > NW) ? lcs_pkg::POS_W : NW) + 2;
	localparam int unsigned MW    = SW + PW + 1;
	localparam int unsigned VW    = ((MW > BW) ? MW : BW) + 1;

	lcs_pkg::lcs_state_t state_q, state_d;

	logic [NW-1:0]          clr_q;
	logic                   kind_q;
	logic signed [SW-1:0]   ins_s_q, cur_s_q, old_s_q;
	logic signed [BW-1:0]   ins_b_q, cur_b_q, old_b_q;
	logic [NW:0]            l_q, r_q;
	logic [LW-1:0]          lvl_q, sh_q;
	logic [NW-1:0]          node_q;
	logic [PW-1:0]          lo_q, qx_q;
	logic signed [VW-1:0]   best_q, prod_new_q, prod_old_q;
	logic                   done_q;
	logic signed [lcs_pkg::VALUE_W-1:0] max_value_q;

	// RAM port
	logic                   ram_we;
	logic [NW-1:0]          ram_waddr;
	logic [lcs_pkg::LINE_W-1:0] ram_wdata, ram_rdata;
	logic signed [SW-1:0]   rd_s;
	logic signed [BW-1:0]   rd_b;

	// input decode
	logic [CW-1:0] first_c, last_c, leaves_c, last_sat, qx_c;
	logic [CW-1:0] l_init, r_init;
	logic          ins_ok, q_out;

	// cover walk
	logic          cov_more, l_odd, r_odd;
	logic [NW:0]   r_m1;
	logic [NW-1:0] push_node, push_shift;

	// node evaluation
	logic [PW-1:0]        half, mid, mx;
	logic signed [PW:0]   mx_s;
	logic signed [MW-1:0] pn_w, po_w;
	logic signed [VW-1:0] new_v, old_v, best_nxt;
	logic                 new_wins, go_left;
	logic signed [SW-1:0] win_s, lose_s;
	logic signed [BW-1:0] lose_b;
	logic                 last_node;

	assign first_c  = CW'(x_first);
	assign last_c   = CW'(x_last);
	assign leaves_c = CW'(LEAVES);
	assign qx_c     = CW'(query_x);
	assign last_sat = (last_c >= leaves_c) ? (leaves_c - CW'(1)) : last_c;
	assign ins_ok   = (first_c <= last_c) && (first_c < leaves_c);
	assign q_out    = (qx_c >= leaves_c);
	assign l_init   = first_c + CW'(TREE);
	assign r_init   = last_sat + CW'(1) + CW'(TREE);

	assign cov_more   = (l_q < r_q);
	assign l_odd      = l_q[0];
	assign r_odd      = r_q[0];
	assign r_m1       = r_q - (NW+1)'(1);
	assign push_node  = l_odd ? l_q[NW-1:0] : r_m1[NW-1:0];
	// node << level lands in [T, 2T); its low bits are the node's left edge
	assign push_shift = push_node << lvl_q;

	assign half = (sh_q == '0) ? '0 : (PW'(1) << (sh_q - LW'(1)));
	assign mid  = lo_q | half;
	assign mx   = (kind_q == lcs_pkg::KIND_QUERY) ? qx_q : mid;
	assign mx_s = {1'b0, mx};

	assign rd_s = ram_rdata[lcs_pkg::LINE_W-1:BW];
	assign rd_b = ram_rdata[BW-1:0];
	assign pn_w = cur_s_q * mx_s;
	assign po_w = rd_s * mx_s;

	assign new_v    = prod_new_q + VW'(cur_b_q);
	assign old_v    = prod_old_q + VW'(old_b_q);
	assign new_wins = (new_v > old_v);
	assign win_s    = new_wins ? cur_s_q : old_s_q;
	assign lose_s   = new_wins ? old_s_q : cur_s_q;
	assign lose_b   = new_wins ? old_b_q : cur_b_q;
	assign go_left  = (win_s > lose_s);
	assign best_nxt = (old_v > best_q) ? old_v : best_q;
	assign last_node = (node_q == NW'(1));

	lcs_ram #(
		.WIDTH(lcs_pkg::LINE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(node_q),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lcs_pkg::ST_CLEAR: begin
				if (&clr_q) state_d = lcs_pkg::ST_IDLE;
			end
			lcs_pkg::ST_IDLE: begin
				if (start) begin
					if (kind == lcs_pkg::KIND_QUERY) begin
						if (!q_out) state_d = lcs_pkg::ST_RD;
					end else if (ins_ok) begin
						state_d = lcs_pkg::ST_COVER;
					end
				end
			end
			lcs_pkg::ST_COVER: begin
				if (!cov_more) state_d = lcs_pkg::ST_IDLE;
				else if (l_odd || r_odd) state_d = lcs_pkg::ST_RD;
			end
			lcs_pkg::ST_RD:  state_d = lcs_pkg::ST_MUL;
			lcs_pkg::ST_MUL: state_d = lcs_pkg::ST_CMP;
			lcs_pkg::ST_CMP: begin
				if (kind_q == lcs_pkg::KIND_QUERY) begin
					state_d = last_node ? lcs_pkg::ST_IDLE : lcs_pkg::ST_RD;
				end else begin
					state_d = (sh_q == '0) ? lcs_pkg::ST_COVER : lcs_pkg::ST_RD;
				end
			end
			default: state_d = lcs_pkg::ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		busy      = (state_q != lcs_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = node_q;
		ram_wdata = {cur_s_q, cur_b_q};
		case (state_q)
			lcs_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = {lcs_pkg::CLR_SLOPE, lcs_pkg::CLR_ICPT};
			end
			lcs_pkg::ST_CMP: begin
				ram_we = (kind_q == lcs_pkg::KIND_INSERT) && new_wins;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign done      = done_q;
	assign max_value = max_value_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lcs_pkg::ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (state_q == lcs_pkg::ST_CLEAR) clr_q <= clr_q + NW'(1);
			if (state_q == lcs_pkg::ST_IDLE && start && kind == lcs_pkg::KIND_QUERY && q_out)
				done_q <= 1'b1;
			if (state_q == lcs_pkg::ST_CMP && kind_q == lcs_pkg::KIND_QUERY && last_node)
				done_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			lcs_pkg::ST_IDLE: begin
				kind_q  <= kind;
				ins_s_q <= line_slope;
				ins_b_q <= line_intercept;
				l_q     <= l_init[NW:0];
				r_q     <= r_init[NW:0];
				lvl_q   <= '0;
				qx_q    <= PW'(query_x);
				node_q  <= {1'b1, PW'(query_x)};
				best_q  <= '1;
				if (start && kind == lcs_pkg::KIND_QUERY && q_out) max_value_q <= '1;
			end
			lcs_pkg::ST_COVER: begin
				if (cov_more) begin
					if (l_odd || r_odd) begin
						node_q  <= push_node;
						lo_q    <= push_shift[PW-1:0];
						sh_q    <= lvl_q;
						cur_s_q <= ins_s_q;
						cur_b_q <= ins_b_q;
						if (l_odd) l_q <= l_q + (NW+1)'(1);
						else r_q <= r_m1;
					end else begin
						l_q   <= l_q >> 1;
						r_q   <= r_q >> 1;
						lvl_q <= lvl_q + LW'(1);
					end
				end
			end
			lcs_pkg::ST_MUL: begin
				old_s_q    <= rd_s;
				old_b_q    <= rd_b;
				prod_new_q <= VW'(pn_w);
				prod_old_q <= VW'(po_w);
			end
			lcs_pkg::ST_CMP: begin
				if (kind_q == lcs_pkg::KIND_QUERY) begin
					best_q <= best_nxt;
					node_q <= node_q >> 1;
					if (last_node) max_value_q <= lcs_pkg::VALUE_W'(best_nxt);
				end else begin
					// loser descends toward the side where it can still win
					cur_s_q <= lose_s;
					cur_b_q <= lose_b;
					if (sh_q != '0) begin
						node_q <= {node_q[NW-2:0], !go_left};
						if (!go_left) lo_q <= mid;
						sh_q <= sh_q - LW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	`LCS_ASSERT_NXT(a_done_single, clk, arst_n, done_q, !done_q)
	`LCS_ASSERT_IMP(a_write_states, clk, arst_n, ram_we, (state_q == lcs_pkg::ST_CLEAR) || (state_q == lcs_pkg::ST_CMP))
	`LCS_ASSERT_NXT(a_query_done, clk, arst_n, (state_q == lcs_pkg::ST_CMP) && (kind_q == lcs_pkg::KIND_QUERY) && last_node, done_q)
	`LCS_ASSERT_NXT(a_push_ends, clk, arst_n, (state_q == lcs_pkg::ST_CMP) && (kind_q == lcs_pkg::KIND_INSERT) && (sh_q == '0), state_q == lcs_pkg::ST_COVER)
	`LCS_ASSERT_IMP(a_node_nonzero, clk, arst_n, state_q == lcs_pkg::ST_RD, node_q != '0)

endmodule

>>> design/lcs_ram.sv
module lcs_ram #(
	parameter int unsigned WIDTH = lcs_pkg::LINE_W,
	parameter int unsigned DEPTH = 2 * lcs_pkg::LEAVES_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> tb/sv/lcs_max_checker.sv
`timescale 1ns / 100ps

module lcs_max_checker
	import lcs_pkg::*;
#(
	parameter int unsigned LEAVES = LEAVES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic                      kind,
	input  logic signed [SLOPE_W-1:0] line_slope,
	input  logic signed [ICPT_W-1:0]  line_intercept,
	input  logic        [POS_W-1:0]   x_first,
	input  logic        [POS_W-1:0]   x_last,
	input  logic        [POS_W-1:0]   query_x,
	input  logic                      done,
	input  logic signed [VALUE_W-1:0] max_value,
	output int                        errors,
	output int                        pending
);

	localparam int unsigned TREE = 1 << $clog2(LEAVES);

	logic signed [SLOPE_W-1:0] slope_mem [2*TREE];
	logic signed [ICPT_W-1:0]  icpt_mem  [2*TREE];
	longint                    expected_max [$];

	function automatic longint value_at(logic signed [SLOPE_W-1:0] s,
			logic signed [ICPT_W-1:0] c, int x);
		longint sl;
		longint ci;
		sl = s;
		ci = c;
		return sl * longint'(x) + ci;
	endfunction

	// winner at the midpoint stays, loser sinks toward the side where it can still win
	function automatic void push_down(logic signed [SLOPE_W-1:0] s,
			logic signed [ICPT_W-1:0] c, int node, int lo, int hi);
		int                        mid;
		logic signed [SLOPE_W-1:0] ts;
		logic signed [ICPT_W-1:0]  tc;
		while (node < 2 * TREE) begin
			mid = (lo + hi) / 2;
			if (value_at(s, c, mid) > value_at(slope_mem[node], icpt_mem[node], mid)) begin
				ts = slope_mem[node];
				tc = icpt_mem[node];
				slope_mem[node] = s;
				icpt_mem[node] = c;
				s = ts;
				c = tc;
			end
			if (slope_mem[node] > s) begin
				node = 2 * node;
				hi = mid;
			end else begin
				node = 2 * node + 1;
				lo = mid;
			end
		end
	endfunction

	function automatic void cover_range(logic signed [SLOPE_W-1:0] s,
			logic signed [ICPT_W-1:0] c, int first, int stop, int node, int lo, int hi);
		int mid;
		if (first >= hi || stop <= lo)
			return;
		if (first <= lo && hi <= stop) begin
			push_down(s, c, node, lo, hi);
			return;
		end
		mid = (lo + hi) / 2;
		cover_range(s, c, first, stop, 2 * node, lo, mid);
		cover_range(s, c, first, stop, 2 * node + 1, mid, hi);
	endfunction

	function automatic void tree_insert(logic signed [SLOPE_W-1:0] s,
			logic signed [ICPT_W-1:0] c, int first, int last);
		if (first > last || first >= LEAVES)
			return;
		if (last >= LEAVES)
			last = LEAVES - 1;
		cover_range(s, c, first, last + 1, 1, 0, TREE);
	endfunction

	function automatic longint tree_max_at(int x);
		longint best;
		longint v;
		best = -1;
		if (x < LEAVES) begin
			for (int node = x + TREE; node != 0; node = node / 2) begin
				v = value_at(slope_mem[node], icpt_mem[node], x);
				if (v > best)
					best = v;
			end
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		longint want;
		if (!arst_n) begin
			for (int i = 0; i < 2 * TREE; i++) begin
				slope_mem[i] = CLR_SLOPE;
				icpt_mem[i] = CLR_ICPT;
			end
			expected_max.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (expected_max.size() == 0) begin
					$error("max_value: no result expected, got %0d", max_value);
					errors++;
				end else begin
					want = expected_max.pop_front();
					if (max_value !== want) begin
						$error("max_value: expected %0d, got %0d", want, max_value);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				if (kind == KIND_QUERY)
					expected_max.push_back(tree_max_at(int'(query_x)));
				else
					tree_insert(line_slope, line_intercept, int'(x_first), int'(x_last));
			end
		end
		pending = expected_max.size();
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import lcs_pkg::*;

	localparam int RANDOM_BEATS = 1500;
	localparam int STALL_LIMIT  = 50000;
	localparam int TAIL_CYCLES  = 20;

	localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
	localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
	localparam logic signed [ICPT_W-1:0]  ICPT_MAX  = {1'b0, {(ICPT_W-1){1'b1}}};
	localparam logic signed [ICPT_W-1:0]  ICPT_MIN  = {1'b1, {(ICPT_W-1){1'b0}}};
	localparam logic        [POS_W-1:0]   X_TOP     = '1;

	logic                      clk            = 1'b0;
	logic                      arst_n         = 1'b0;
	logic                      start          = 1'b0;
	logic                      kind           = KIND_INSERT;
	logic signed [SLOPE_W-1:0] line_slope     = '0;
	logic signed [ICPT_W-1:0]  line_intercept = '0;
	logic        [POS_W-1:0]   x_first        = '0;
	logic        [POS_W-1:0]   x_last         = '0;
	logic        [POS_W-1:0]   query_x        = '0;
	logic                      busy;
	logic                      done;
	logic signed [VALUE_W-1:0] max_value;

	int errors;
	int pending;
	int stall_cycles = 0;
	int no_gap_left  = 0;

	always #4 clk = ~clk;

	li_chao_segment_max u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.line_slope     (line_slope),
		.line_intercept (line_intercept),
		.x_first        (x_first),
		.x_last         (x_last),
		.query_x        (query_x),
		.done           (done),
		.max_value      (max_value)
	);

	lcs_max_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.kind           (kind),
		.line_slope     (line_slope),
		.line_intercept (line_intercept),
		.x_first        (x_first),
		.x_last         (x_last),
		.query_x        (query_x),
		.done           (done),
		.max_value      (max_value),
		.errors         (errors),
		.pending        (pending)
	);

	// includes the clearing pass after reset, which runs with busy high
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	function automatic logic signed [SLOPE_W-1:0] pick_slope();
		case ($urandom_range(0, 3))
			0: return SLOPE_W'($urandom);
			1: return SLOPE_W'(int'($urandom_range(0, 16)) - 8);
			2: return $urandom_range(0, 1) ? SLOPE_MAX : SLOPE_MIN;
			default: return SLOPE_W'(int'($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	function automatic logic signed [ICPT_W-1:0] pick_icpt();
		case ($urandom_range(0, 3))
			0: return ICPT_W'({$urandom, $urandom});
			1: return ICPT_W'(int'($urandom_range(0, 16)) - 8);
			2: return $urandom_range(0, 1) ? ICPT_MAX : ICPT_MIN;
			default: return ICPT_W'(longint'($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	// called at a rising edge; returns at the edge that takes the beat
	task automatic send_beat(input logic k, input logic signed [SLOPE_W-1:0] s,
			input logic signed [ICPT_W-1:0] c, input logic [POS_W-1:0] f,
			input logic [POS_W-1:0] l, input logic [POS_W-1:0] q);
		int gap;
		if (no_gap_left > 0) begin
			no_gap_left--;
			gap = 0;
		end else begin
			gap = $urandom_range(0, 3);
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		line_slope <= s;
		line_intercept <= c;
		x_first <= f;
		x_last <= l;
		query_x <= q;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic ask_max(input logic [POS_W-1:0] q);
		send_beat(KIND_QUERY, pick_slope(), pick_icpt(), POS_W'($urandom),
			POS_W'($urandom), q);
	endtask

	task automatic add_line(input logic signed [SLOPE_W-1:0] s,
			input logic signed [ICPT_W-1:0] c, input logic [POS_W-1:0] f,
			input logic [POS_W-1:0] l);
		send_beat(KIND_INSERT, s, c, f, l, POS_W'($urandom));
	endtask

	initial begin
		int lo_x;
		int hi_x;
		int t;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty tree answers -1
		ask_max('0);
		ask_max(X_TOP);
		add_line('0, 48'sd5, '0, X_TOP);
		ask_max(10'd512);
		add_line(SLOPE_MAX, ICPT_MIN, '0, X_TOP);
		ask_max(X_TOP);
		ask_max('0);
		add_line(SLOPE_MIN, ICPT_MAX, 10'd3, 10'd700);
		// reversed range leaves the tree alone
		add_line(SLOPE_MAX, ICPT_MAX, 10'd900, 10'd100);
		ask_max(10'd500);
		add_line(-32'sd1, ICPT_MAX, '0, '0);
		add_line(-32'sd1, ICPT_MAX, X_TOP, X_TOP);
		ask_max('0);
		ask_max(X_TOP);
		ask_max(10'd700);
		ask_max(10'd701);
		add_line(-32'sd5, -48'sd1, 10'd1, 10'd1);
		add_line('1, '1, X_TOP, X_TOP);
		ask_max(10'd1);
		ask_max(10'd2);
		ask_max(X_TOP);
		ask_max(10'd511);

		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if ($urandom_range(0, 19) == 0)
				no_gap_left = 20;
			if ($urandom_range(0, 9) < 6) begin
				ask_max(POS_W'($urandom));
			end else begin
				lo_x = $urandom_range(0, 1023);
				hi_x = $urandom_range(0, 1023);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						hi_x = lo_x + $urandom_range(0, 31);
						if (hi_x > 1023)
							hi_x = 1023;
					end
					5: begin
						lo_x = 0;
						hi_x = 1023;
					end
					6: ;
					default: begin
						if (lo_x > hi_x) begin
							t = lo_x;
							lo_x = hi_x;
							hi_x = t;
						end
					end
				endcase
				add_line(pick_slope(), pick_icpt(), POS_W'(lo_x), POS_W'(hi_x));
			end
		end
		start <= 1'b0;
		// let the checker see the last beat before looking at pending
		@(posedge clk);

		while (pending != 0 || busy)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> li_chao_segment_max.f
+incdir+design
design/lcs_pkg.sv
design/lcs_ram.sv
design/li_chao_segment_max.sv
tb/sv/lcs_max_checker.sv
tb/sv/testbench.sv
